[rtl/core/avplr_pkg.sv]
// package: shared types, pair ids and trailer constants of the av pair list rewriter
`timescale 1ns / 1ps

package avplr_pkg;

  localparam logic [15:0] ID_EOL   = 16'h0000;
  localparam logic [15:0] ID_FLAGS = 16'h0006;
  localparam logic [15:0] ID_TNAME = 16'h0009;
  localparam logic [15:0] FLAGS_LEN = 16'h0004;
  localparam logic [31:0] MIC_BIT  = 32'h0000_0002;

  localparam logic [7:0] MIC_BYTE = MIC_BIT[7:0];

  // register byte addresses
  localparam logic [1:0] ADDR_APPEND_NAME = 2'd0;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_VALUE,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    MODE_COPY,
    MODE_DROP,
    MODE_FLAGS
  } mode_e;

  typedef enum logic [1:0] {
    SEG_HDR,
    SEG_FLAGS,
    SEG_NAME,
    SEG_EOL
  } seg_e;

  // byte k of the default flags pair: 0006 0004 00000002, little endian
  function automatic logic [7:0] flags_byte(input logic [2:0] k);
    logic [63:0] pair;
    pair = {MIC_BIT, FLAGS_LEN, ID_FLAGS};
    return pair[8*k +: 8];
  endfunction

  // utf-16le target name, high bytes zero
  function automatic logic [7:0] name_byte(input logic [6:0] i);
    logic [7:0] ch;
    unique case (i[3:1])
      3'd0:    ch = 8'h54; // T
      3'd1:    ch = 8'h45; // E
      3'd2:    ch = 8'h52; // R
      3'd3:    ch = 8'h4D; // M
      3'd4:    ch = 8'h53; // S
      3'd5:    ch = 8'h52; // R
      3'd6:    ch = 8'h56; // V
      default: ch = 8'h00;
    endcase
    if (i[0] || (i[6:1] >= 6'd7)) begin
      ch = 8'h00;
    end
    return ch;
  endfunction

endpackage

[rtl/core/av_pair_list_rewriter.sv]
// top level: byte-serial av pair list rewriter with trailer insertion
// latency: a word taken at the input that yields a job shows its first result word in the next cycle
// throughput: one input word per cycle while each word yields at most one result word and
//   out_stall_i stays low; a completed pair header drains four words and the trailer up to
//   8 + 4 + NAME_BYTES + 4, input stalls meanwhile, set by the single result word sequencer
// reset: rst_ni async low clears list state, empties the result stage, append flag to 1
`timescale 1ns / 1ps

module av_pair_list_rewriter #(
  parameter int NAME_BYTES = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] buffer_length_i,
  input  logic        is_last_i,
  // result word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer counter covers the longest trailer segment (name pair)
  localparam int CW = $clog2(NAME_BYTES + 5);
  localparam logic [15:0] NAME_LEN = 16'(NAME_BYTES);
  localparam logic HAS_NAME = (NAME_BYTES > 0);

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  logic append_q;

  assign pready = 1'b1;
  assign prdata = (paddr == avplr_pkg::ADDR_APPEND_NAME) ? {31'd0, append_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_q <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr == avplr_pkg::ADDR_APPEND_NAME) begin
      append_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // list parser state
  // ---------------------------------------------------------------------------
  logic [15:0]         pos_q, pos_d;
  logic [15:0]         len_q, len_d;
  logic [23:0]         hb_q, hb_d;        // header bytes gathered so far
  logic [15:0]         vbl_q, vbl_d;      // header count, or value bytes left
  avplr_pkg::phase_e   phase_q, phase_d;
  avplr_pkg::mode_e    mode_q, mode_d;
  logic                fseen_q, fseen_d;

  // result stage: one job per accepted word that yields result words or ends a list
  logic                job_q;
  logic [31:0]         jhdr_q;
  logic [2:0]          jn_q;              // leading bytes from jhdr (0, 1 or 4)
  logic                jlast_q;
  logic                jflags_q;
  logic                jname_q;
  avplr_pkg::seg_e     seg_q;
  logic [CW-1:0]       cnt_q;

  // job being built from the incoming word
  logic [31:0]         nhdr;
  logic [2:0]          nn;
  logic                nflags;
  logic                nname;

  logic [15:0] lat_len;
  logic        in_range;
  logic [31:0] full_hdr;
  logic [15:0] hid, hlen, room;

  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    hb_d    = hb_q;
    vbl_d   = vbl_q;
    phase_d = phase_q;
    mode_d  = mode_q;
    fseen_d = fseen_q;
    nhdr    = 32'd0;
    nn      = 3'd0;

    // length is sampled with the first word of a list
    lat_len  = (pos_q == 16'd0) ? buffer_length_i : len_q;
    len_d    = lat_len;
    in_range = pos_q < lat_len;
    full_hdr = {data_byte_i, hb_q};
    hid      = full_hdr[15:0];
    hlen     = full_hdr[31:16];
    room     = lat_len - pos_q - 16'd1;

    if (in_range) begin
      unique case (phase_q)
        avplr_pkg::PH_HEADER: begin
          if (vbl_q[1:0] == 2'd3) begin
            vbl_d = 16'd0;
            hb_d  = 24'd0;
            if (hid == avplr_pkg::ID_EOL || hlen > room) begin
              phase_d = avplr_pkg::PH_DONE;
            end else begin
              if (hid == avplr_pkg::ID_TNAME) begin
                mode_d = avplr_pkg::MODE_DROP;
              end else begin
                nhdr = full_hdr;
                nn   = 3'd4;
                if (hid == avplr_pkg::ID_FLAGS && hlen == avplr_pkg::FLAGS_LEN) begin
                  mode_d  = avplr_pkg::MODE_FLAGS;
                  fseen_d = 1'b1;
                end else begin
                  mode_d = avplr_pkg::MODE_COPY;
                end
              end
              if (hlen == 16'd0) begin
                phase_d = avplr_pkg::PH_HEADER;
              end else begin
                vbl_d   = hlen;
                phase_d = avplr_pkg::PH_VALUE;
              end
            end
          end else begin
            hb_d  = hb_q | (24'(data_byte_i) << {vbl_q[1:0], 3'd0});
            vbl_d = vbl_q + 16'd1;
          end
        end
        avplr_pkg::PH_VALUE: begin
          case (mode_q)
            avplr_pkg::MODE_COPY: begin
              nhdr = {24'd0, data_byte_i};
              nn   = 3'd1;
            end
            avplr_pkg::MODE_FLAGS: begin
              // mic bit goes into the first value byte
              nhdr = {24'd0, (vbl_q == 16'd4) ? (data_byte_i | avplr_pkg::MIC_BYTE)
                                               : data_byte_i};
              nn   = 3'd1;
            end
            default: ;
          endcase
          if (vbl_q != 16'd0) begin
            vbl_d = vbl_q - 16'd1;
          end
          if (vbl_q <= 16'd1) begin
            phase_d = avplr_pkg::PH_HEADER;
          end
        end
        default: ;
      endcase
    end

    // saturating position
    if (pos_q != 16'hFFFF) begin
      pos_d = pos_q + 16'd1;
    end

    nflags = !fseen_d;
    nname  = append_q && HAS_NAME;

    // end of list returns parser state to reset
    if (is_last_i) begin
      pos_d   = 16'd0;
      len_d   = 16'd0;
      hb_d    = 24'd0;
      vbl_d   = 16'd0;
      phase_d = avplr_pkg::PH_HEADER;
      mode_d  = avplr_pkg::MODE_COPY;
      fseen_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result word sequencer
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    seg_end;
  logic             seg_done;
  logic             has_next;
  avplr_pkg::seg_e  next_seg;
  avplr_pkg::seg_e  start_seg;
  logic             out_fire;
  logic             job_done;
  logic             in_fire;
  logic [CW-1:0]    name_idx;

  always_comb begin
    unique case (seg_q)
      avplr_pkg::SEG_HDR:   seg_end = CW'(jn_q - 3'd1);
      avplr_pkg::SEG_FLAGS: seg_end = CW'(7);
      avplr_pkg::SEG_NAME:  seg_end = CW'(NAME_BYTES + 3);
      default:              seg_end = CW'(3);
    endcase
  end

  // what follows the current segment
  always_comb begin
    has_next = 1'b1;
    next_seg = avplr_pkg::SEG_EOL;
    unique case (seg_q)
      avplr_pkg::SEG_HDR: begin
        has_next = jlast_q;
        if (jflags_q) begin
          next_seg = avplr_pkg::SEG_FLAGS;
        end else if (jname_q) begin
          next_seg = avplr_pkg::SEG_NAME;
        end
      end
      avplr_pkg::SEG_FLAGS: begin
        if (jname_q) begin
          next_seg = avplr_pkg::SEG_NAME;
        end
      end
      avplr_pkg::SEG_NAME: ;
      default: has_next = 1'b0;
    endcase
  end

  always_comb begin
    if (nn != 3'd0) begin
      start_seg = avplr_pkg::SEG_HDR;
    end else if (nflags) begin
      start_seg = avplr_pkg::SEG_FLAGS;
    end else if (nname) begin
      start_seg = avplr_pkg::SEG_NAME;
    end else begin
      start_seg = avplr_pkg::SEG_EOL;
    end
  end

  assign seg_done   = cnt_q == seg_end;
  assign out_fire   = job_q && !out_stall_i;
  assign job_done   = out_fire && seg_done && !has_next;
  // next word is taken as soon as the current job hands over its final word
  assign in_stall_o = job_q && !job_done;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 16'd0;
      len_q   <= 16'd0;
      hb_q    <= 24'd0;
      vbl_q   <= 16'd0;
      phase_q <= avplr_pkg::PH_HEADER;
      mode_q  <= avplr_pkg::MODE_COPY;
      fseen_q <= 1'b0;
      job_q   <= 1'b0;
      seg_q   <= avplr_pkg::SEG_HDR;
      cnt_q   <= '0;
    end else begin
      if (in_fire) begin
        pos_q   <= pos_d;
        len_q   <= len_d;
        hb_q    <= hb_d;
        vbl_q   <= vbl_d;
        phase_q <= phase_d;
        mode_q  <= mode_d;
        fseen_q <= fseen_d;
        job_q   <= (nn != 3'd0) || is_last_i;
        seg_q   <= start_seg;
        cnt_q   <= '0;
      end else if (job_done) begin
        job_q <= 1'b0;
      end else if (out_fire) begin
        if (seg_done) begin
          seg_q <= next_seg;
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  // job payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      jhdr_q   <= nhdr;
      jn_q     <= nn;
      jlast_q  <= is_last_i;
      jflags_q <= nflags;
      jname_q  <= nname;
    end
  end

  // ---------------------------------------------------------------------------
  // result word select
  // ---------------------------------------------------------------------------
  assign name_idx = cnt_q - CW'(4);

  always_comb begin
    out_byte_o = 8'd0;
    unique case (seg_q)
      avplr_pkg::SEG_HDR:   out_byte_o = jhdr_q[{cnt_q[1:0], 3'd0} +: 8];
      avplr_pkg::SEG_FLAGS: out_byte_o = avplr_pkg::flags_byte(cnt_q[2:0]);
      avplr_pkg::SEG_NAME: begin
        case (cnt_q)
          CW'(0):  out_byte_o = avplr_pkg::ID_TNAME[7:0];
          CW'(1):  out_byte_o = avplr_pkg::ID_TNAME[15:8];
          CW'(2):  out_byte_o = NAME_LEN[7:0];
          CW'(3):  out_byte_o = NAME_LEN[15:8];
          default: out_byte_o = avplr_pkg::name_byte(7'(name_idx));
        endcase
      end
      default:              out_byte_o = 8'd0;  // end-of-list pair is all zero
    endcase
  end

  assign out_valid_o = job_q;
  assign out_last_o  = (seg_q == avplr_pkg::SEG_EOL) && (cnt_q == CW'(3));

`ifndef SYNTHESIS
  // input only stalls while a job drains
  a_stall_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result stage");

  // a job without end of list only carries pair bytes
  a_trailer_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_q && !jlast_q) |-> (seg_q == avplr_pkg::SEG_HDR))
    else $error("trailer segment outside a final job");

  // value phase always has bytes outstanding
  a_value_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == avplr_pkg::PH_VALUE) |-> (vbl_q != 16'd0))
    else $error("value phase with no bytes left");
`endif

endmodule

[tb/pair_rewrite_tracker_pkg.sv]
// package: expected-word tracker for the av pair list rewriter testbench
`timescale 1ns / 1ps

package pair_rewrite_tracker_pkg;

  import avplr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  localparam logic [55:0] TNAME_TEXT = "TERMSRV";

  class pair_rewrite_tracker;

    int          name_bytes;
    bit          append_name;
    logic [15:0] list_pos;
    logic [15:0] buf_len;
    logic [15:0] left;
    logic [31:0] hdr_acc;
    phase_e      phase;
    mode_e       mode;
    bit          flags_done;
    out_word_t   rewritten_bytes[$];
    int unsigned errors;

    function new(int nb);
      name_bytes  = nb;
      append_name = 1'b1;
      errors      = 0;
      clear_list();
    endfunction

    function void clear_list();
      list_pos   = '0;
      buf_len    = '0;
      left       = '0;
      hdr_acc    = '0;
      phase      = PH_HEADER;
      mode       = MODE_COPY;
      flags_done = 1'b0;
    endfunction

    function void set_append(bit v);
      append_name = v;
    endfunction

    function int unsigned pending();
      return rewritten_bytes.size();
    endfunction

    function void expect_byte(logic [7:0] b, logic l);
      rewritten_bytes.push_back('{data: b, last: l});
    endfunction

    function void expect_u16(logic [15:0] v, logic last_hi);
      expect_byte(v[7:0], 1'b0);
      expect_byte(v[15:8], last_hi);
    endfunction

    // one accepted list word: parse step, then the trailer on the final word
    function void take_list_byte(logic [7:0] b, logic [15:0] blen, logic is_last);
      logic [15:0] id;
      logic [15:0] len;
      logic [31:0] room;
      if (list_pos == 16'd0) buf_len = blen;
      if (list_pos < buf_len) begin
        if (phase == PH_HEADER) begin
          hdr_acc = hdr_acc | (32'(b) << (8 * left[1:0]));
          left = left + 16'd1;
          if (left >= 16'd4) begin
            id   = hdr_acc[15:0];
            len  = hdr_acc[31:16];
            room = 32'(buf_len) - (32'(list_pos) + 32'd1);
            left = '0;
            hdr_acc = '0;
            if (id == ID_EOL || 32'(len) > room) begin
              phase = PH_DONE;
            end else begin
              if (id == ID_TNAME) begin
                mode = MODE_DROP;
              end else begin
                expect_u16(id, 1'b0);
                expect_u16(len, 1'b0);
                if (id == ID_FLAGS && len == FLAGS_LEN) begin
                  mode = MODE_FLAGS;
                  flags_done = 1'b1;
                end else begin
                  mode = MODE_COPY;
                end
              end
              if (len == 16'd0) begin
                phase = PH_HEADER;
              end else begin
                left  = len;
                phase = PH_VALUE;
              end
            end
          end
        end else if (phase == PH_VALUE) begin
          if (mode == MODE_COPY) begin
            expect_byte(b, 1'b0);
          end else if (mode == MODE_FLAGS) begin
            expect_byte((left == 16'd4) ? (b | MIC_BIT[7:0]) : b, 1'b0);
          end
          if (left != 16'd0) left = left - 16'd1;
          if (left == 16'd0) phase = PH_HEADER;
        end
      end
      if (list_pos != 16'hFFFF) list_pos = list_pos + 16'd1;
      if (is_last) begin
        if (!flags_done) begin
          expect_u16(ID_FLAGS, 1'b0);
          expect_u16(FLAGS_LEN, 1'b0);
          expect_u16(MIC_BIT[15:0], 1'b0);
          expect_u16(MIC_BIT[31:16], 1'b0);
        end
        if (append_name && name_bytes > 0) begin
          expect_u16(ID_TNAME, 1'b0);
          expect_u16(16'(name_bytes), 1'b0);
          for (int i = 0; i < name_bytes; i++) begin
            if (i % 2 == 0 && i / 2 < 7) begin
              expect_byte(TNAME_TEXT[8 * (6 - i / 2) +: 8], 1'b0);
            end else begin
              expect_byte(8'h00, 1'b0);
            end
          end
        end
        expect_u16(ID_EOL, 1'b0);
        expect_u16(16'h0000, 1'b1);
        clear_list();
      end
    endfunction

    function void match_out_byte(logic [7:0] b, logic l);
      out_word_t want;
      if (rewritten_bytes.size() == 0) begin
        $display("%0t: unexpected out word, byte %02h last %0b", $time, b, l);
        errors++;
        return;
      end
      want = rewritten_bytes.pop_front();
      if (want.data !== b) begin
        $display("%0t: out_byte expected %02h got %02h", $time, want.data, b);
        errors++;
      end
      if (want.last !== l) begin
        $display("%0t: out_last expected %0b got %0b", $time, want.last, l);
        errors++;
      end
    endfunction

  endclass

endpackage

[tb/av_pair_list_rewriter_test.sv]
// testbench top: random and directed av pair lists through the rewriter, checked word by word
`timescale 1ns / 1ps

module av_pair_list_rewriter_test;

  import avplr_pkg::*;
  import pair_rewrite_tracker_pkg::*;

  localparam int NAME_BYTES = 14;

  // every input known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic [7:0]  data_byte_i     = '0;
  logic [15:0] buffer_length_i = '0;
  logic        is_last_i       = 1'b0;
  logic        out_stall_i     = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [1:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic [31:0] prdata;
  logic        pready;

  pair_rewrite_tracker tracker;

  // set for the closing stretch: no gaps from the sender, no stalls from the receiver
  bit          calm = 1'b0;
  int          stall_left = 0;
  // the list being sent, one entry per word
  logic [7:0]  list_bytes[$];

  av_pair_list_rewriter #(
    .NAME_BYTES(NAME_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .buffer_length_i(buffer_length_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // receiver back-pressure: random stall bursts, otherwise free running
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result side: a word moves on an edge with valid high and stall low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.match_out_byte(out_byte_o, out_last_o);
    end
  end

  // present one list word, possibly after an idle burst, and hold it until taken
  task automatic send_list_byte(input logic [7:0] b, input logic [15:0] blen,
                                input logic is_last);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    buffer_length_i <= blen;
    is_last_i       <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_list_byte(b, blen, is_last);
  endtask

  // send the first cut words of list_bytes (random filler past its end), is_last on the
  // final one; buffer_length only matters on the first word, so the rest carry noise
  task automatic send_list(input logic [15:0] blen, input int unsigned cut,
                           input int drain_at);
    for (int unsigned i = 0; i < cut; i++) begin
      // mid-list pause until the result side has caught up completely
      if (i != 0 && int'(i) == drain_at) drain_results();
      send_list_byte((i < list_bytes.size()) ? list_bytes[i] : 8'($urandom),
                     (i == 0) ? blen : 16'($urandom), i == cut - 1);
    end
  endtask

  // always waits for a clock edge first, so valid is never lowered and raised in one step
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_APPEND_NAME;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_append_name(input bit want);
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    if (rd[0] !== want) begin
      $display("%0t: append_target_name read expected %0b got %0b", $time, want, rd[0]);
      tracker.errors++;
    end
  endtask

  // only called once the list is finished and every result word has been seen
  task automatic program_append_name(input bit v);
    logic [31:0] wd;
    logic [31:0] rd;
    // a word can end in no result, so let the pipeline empty before the write
    repeat (4) @(posedge clk_i);
    wd    = $urandom;
    wd[0] = v;
    apb_access(1'b1, wd, rd);
    tracker.set_append(v);
    read_append_name(v);
  endtask

  function automatic void push_u16(logic [15:0] v);
    list_bytes.push_back(v[7:0]);
    list_bytes.push_back(v[15:8]);
  endfunction

  // mostly well-formed pair lists with random content, some plain noise
  function automatic void build_random_list();
    int          npairs;
    logic [15:0] id;
    logic [15:0] len;
    list_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) list_bytes.push_back(8'($urandom));
      return;
    end
    npairs = $urandom_range(0, 4);
    for (int p = 0; p < npairs; p++) begin
      case ($urandom_range(0, 6))
        0, 1, 5: begin
          id  = $urandom_range(0, 1) ? 16'($urandom_range(1, 15)) : 16'($urandom);
          if (id == ID_EOL || id == ID_FLAGS || id == ID_TNAME) id = 16'h0001;
          len = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom_range(1, 6));
        end
        2: begin
          id  = ID_FLAGS;
          len = FLAGS_LEN;
        end
        3: begin
          id  = ID_FLAGS;
          len = 16'($urandom_range(0, 7));
        end
        4: begin
          id  = ID_TNAME;
          len = 16'($urandom_range(0, 8));
        end
        default: begin
          // wild header, usually a length that overruns the buffer
          id  = 16'($urandom);
          len = 16'($urandom);
        end
      endcase
      push_u16(id);
      push_u16(len);
      repeat ((len > 16'd8) ? 2 : int'(len)) list_bytes.push_back(8'($urandom));
    end
    case ($urandom_range(0, 3))
      0: begin
        // end of list with any length, then junk that must be ignored
        push_u16(ID_EOL);
        push_u16(16'($urandom));
        repeat ($urandom_range(0, 3)) list_bytes.push_back(8'($urandom));
      end
      1: ;
      2: repeat ($urandom_range(1, 3)) list_bytes.push_back(8'($urandom));
      default: begin
        push_u16(ID_EOL);
        push_u16(16'h0000);
      end
    endcase
    if (list_bytes.size() == 0) list_bytes.push_back(8'($urandom));
  endfunction

  // random lists until about target words fall inside their buffers
  task automatic run_random_lists(input int unsigned target);
    int unsigned taken;
    int unsigned size;
    int unsigned cut;
    logic [15:0] blen;
    int          drain_at;
    taken = 0;
    while (taken < target) begin
      build_random_list();
      size = list_bytes.size();
      case ($urandom_range(0, 9))
        6:       blen = 16'($urandom_range(0, size - 1));
        7:       blen = 16'(size + $urandom_range(1, 8));
        8:       blen = 16'($urandom);
        default: blen = 16'(size);
      endcase
      // now and then the list stops early, cutting a value short
      cut      = ($urandom_range(0, 6) == 0) ? $urandom_range(1, size) : size;
      drain_at = ($urandom_range(0, 14) == 0) ? int'(cut / 2) : -1;
      send_list(blen, cut, drain_at);
      taken += (cut < blen) ? cut : blen;
    end
  endtask

  initial begin
    tracker = new(NAME_BYTES);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_append_name(1'b1);

    // zero buffer length: nothing parsed, trailer only
    list_bytes = '{8'hFF};
    send_list(16'h0000, 1, -1);
    // a lone byte is only a partial header
    list_bytes = '{8'h00};
    send_list(16'h0001, 1, -1);
    // flags pair gets the mic bit, empty target name dropped, end of list; pause midway
    list_bytes = '{8'h06, 8'h00, 8'h04, 8'h00, 8'hFD, 8'hFF, 8'hFF, 8'hFF,
                   8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_list(16'd16, 16, 8);
    // copied value cut short by an early last word
    list_bytes = '{8'h01, 8'h00, 8'h03, 8'h00, 8'h12};
    send_list(16'd10, 5, -1);
    // length overruns the buffer, and one word lies past the buffer
    list_bytes = '{8'h02, 8'h00, 8'hFF, 8'hFF, 8'h77};
    send_list(16'd4, 5, -1);

    drain_results();
    program_append_name(1'b0);
    run_random_lists(32);

    drain_results();
    program_append_name(1'b1);
    run_random_lists(32);

    drain_results();
    program_append_name(1'b0);
    run_random_lists(32);

    drain_results();
    program_append_name(1'b1);
    calm = 1'b1;
    run_random_lists(32);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[av_pair_list_rewriter.f]
rtl/core/avplr_pkg.sv
rtl/core/av_pair_list_rewriter.sv
tb/pair_rewrite_tracker_pkg.sv
tb/av_pair_list_rewriter_test.sv
